// File: rtl/core/trle_pkg.sv
// Shared types and constants of the tile run-length byte decoder.
package trle_pkg;

  localparam int INDEX_WIDTH = 20;
  localparam int LIMIT_WIDTH = INDEX_WIDTH + 1;
  localparam int COUNT_WIDTH = 7;
  localparam int RUN_WIDTH   = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = QPTR_WIDTH + 1;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(1048576);
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_CAP   = LIMIT_WIDTH'(1) << INDEX_WIDTH;

  localparam logic [7:0]           REPEAT_BASE  = 8'hC0;
  localparam logic [7:0]           LITERAL_BASE = 8'h80;
  localparam logic [5:0]           REPEAT_MASK  = 6'h3F;
  localparam logic [6:0]           LITERAL_MASK = 7'h7F;
  localparam logic [RUN_WIDTH-1:0] REPEAT_MAX   = RUN_WIDTH'(64);
  localparam logic [RUN_WIDTH-1:0] LITERAL_MAX  = RUN_WIDTH'(128);

  typedef enum logic [1:0] {
    MODE_CMD     = 2'd0,
    MODE_REPEAT  = 2'd1,
    MODE_LITERAL = 2'd2
  } decode_mode_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       start_of_frame;
  } code_item_t;

  typedef struct packed {
    logic [7:0]             pixel_value;
    logic [INDEX_WIDTH-1:0] pixel_index;
    logic                   run_end;
  } pixel_item_t;

  // One queued job: a pixel value written count times from base onwards.
  typedef struct packed {
    logic [7:0]             value;
    logic [INDEX_WIDTH-1:0] base;
    logic [COUNT_WIDTH-1:0] count;
  } job_t;

endpackage

// File: rtl/core/trle_front.sv
// Front end: accept code bytes, track decode mode and pixel count, issue jobs.
module trle_front import trle_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   code_valid,
  output logic                   code_stall,
  input  code_item_t             code,
  input  logic                   limit_valid,
  input  logic [LIMIT_WIDTH-1:0] limit_data,
  input  logic                   queue_full,
  output logic                   job_push,
  output job_t                   job
);

  logic [LIMIT_WIDTH-1:0] pixel_limit;
  decode_mode_t           mode, mode_next;
  logic [RUN_WIDTH-1:0]   run_remaining, run_remaining_next;
  logic [LIMIT_WIDTH-1:0] pixels_written, pixels_written_next;

  decode_mode_t           mode_cur;
  logic [RUN_WIDTH-1:0]   run_cur;
  logic [LIMIT_WIDTH-1:0] pw_cur;
  logic [LIMIT_WIDTH-1:0] lim_eff;
  logic [LIMIT_WIDTH-1:0] room;
  logic [COUNT_WIDTH-1:0] rep_cnt;
  logic [COUNT_WIDTH-1:0] n;
  logic                   accept;
  logic [7:0]             b;

  assign code_stall = queue_full;
  assign accept     = code_valid && !queue_full;
  assign b          = code.code_byte;

  always_comb begin
    mode_cur = code.start_of_frame ? MODE_CMD : mode;
    run_cur  = code.start_of_frame ? '0 : run_remaining;
    pw_cur   = code.start_of_frame ? '0 : pixels_written;
    lim_eff  = (pixel_limit > LIMIT_CAP) ? LIMIT_CAP : pixel_limit;
    room     = lim_eff - pw_cur;
    rep_cnt  = run_cur[COUNT_WIDTH-1:0];

    mode_next           = mode_cur;
    run_remaining_next  = run_cur;
    n                   = '0;
    job_push            = 1'b0;

    if (pw_cur < lim_eff) begin
      unique case (mode_cur)
        MODE_REPEAT: begin
          n = (room < LIMIT_WIDTH'(rep_cnt)) ? room[COUNT_WIDTH-1:0] : rep_cnt;
          job_push           = accept && (n != '0);
          mode_next          = MODE_CMD;
          run_remaining_next = '0;
        end
        MODE_LITERAL: begin
          n                  = COUNT_WIDTH'(1);
          job_push           = accept;
          run_remaining_next = run_cur - RUN_WIDTH'(1);
          if (run_remaining_next == '0) begin
            mode_next = MODE_CMD;
          end
        end
        default: begin
          if (b >= REPEAT_BASE) begin
            run_remaining_next = (b[5:0] & REPEAT_MASK) == '0 ? REPEAT_MAX
                                 : RUN_WIDTH'(b[5:0] & REPEAT_MASK);
            mode_next = MODE_REPEAT;
          end else if (b >= LITERAL_BASE) begin
            run_remaining_next = (b[6:0] & LITERAL_MASK) == '0 ? LITERAL_MAX
                                 : RUN_WIDTH'(b[6:0] & LITERAL_MASK);
            mode_next = MODE_LITERAL;
          end else begin
            mode_next = MODE_CMD;
            n         = COUNT_WIDTH'(1);
            job_push  = accept;
          end
        end
      endcase
    end

    pixels_written_next = pw_cur + LIMIT_WIDTH'(n);

    job.value = b;
    job.base  = pw_cur[INDEX_WIDTH-1:0];
    job.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_limit    <= LIMIT_RESET;
      mode           <= MODE_CMD;
      run_remaining  <= '0;
      pixels_written <= '0;
    end else begin
      if (limit_valid) begin
        pixel_limit <= limit_data;
      end
      if (accept) begin
        mode           <= mode_next;
        run_remaining  <= run_remaining_next;
        pixels_written <= pixels_written_next;
      end
    end
  end

endmodule

// File: rtl/core/trle_queue.sv
// Short job queue between the front end and the pixel writer.
module trle_queue import trle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output job_t head
);

  job_t                  mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;

  assign full     = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_WIDTH'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_WIDTH'(1);
      end
      count <= count + QCNT_WIDTH'(push) - QCNT_WIDTH'(pop);
    end
  end

endmodule

// File: rtl/core/trle_back.sv
// Pixel writer: expand queued jobs into pixels through an output register.
module trle_back import trle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_ready,
  input  job_t        job,
  output logic        job_pop,
  output logic        pixel_valid,
  input  logic        pixel_stall,
  output pixel_item_t pixel
);

  logic                   active;
  logic [7:0]             cur_value;
  logic [INDEX_WIDTH-1:0] cur_index;
  logic [COUNT_WIDTH-1:0] remaining;
  logic                   can_out;
  logic                   emit;
  logic                   last;

  assign can_out = !pixel_valid || !pixel_stall;
  assign emit    = active && can_out;
  assign last    = (remaining == COUNT_WIDTH'(1));
  assign job_pop = job_ready && (!active || (emit && last));

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel.pixel_value <= cur_value;
      pixel.pixel_index <= cur_index;
      pixel.run_end     <= last;
    end
    if (job_pop) begin
      cur_value <= job.value;
      cur_index <= job.base;
      remaining <= job.count;
    end else if (emit) begin
      cur_index <= cur_index + INDEX_WIDTH'(1);
      remaining <= remaining - COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (can_out) begin
        pixel_valid <= active;
      end
      if (job_pop) begin
        active <= 1'b1;
      end else if (emit && last) begin
        active <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/tile_rle_byte_decoder_unit.sv
// Top level of the tile run-length byte decoder.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  code     | code_valid / code_stall   | code_item_t: code_byte, start_of_frame
//  pixel    | pixel_valid / pixel_stall | pixel_item_t: value, index, run_end
//  limit    | limit_valid / limit_ready | limit_data: pixel_limit (21 bits)
//
// A code byte is taken whenever the job queue has room; bytes that
// only arm a run leave no job. The pixel writer sends one pixel a cycle while
// pixel_stall is low, and a repeat gives up to 64 pixels; sustained rate is
// bound by pixel output. A job passes the queue, job and output registers.
// Reset (rst, synchronous) clears mode, run and pixel counts, empties the queue
// and sets the limit to 1048576. Stall on pixel holds the output register; the
// queue fills and then stalls code. Limit writes are taken at any cycle.
module tile_rle_byte_decoder_unit import trle_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   code_valid,
  output logic                   code_stall,
  input  code_item_t             code,
  output logic                   pixel_valid,
  input  logic                   pixel_stall,
  output pixel_item_t            pixel,
  input  logic                   limit_valid,
  output logic                   limit_ready,
  input  logic [LIMIT_WIDTH-1:0] limit_data
);

  logic job_push;
  job_t job_in;
  logic queue_full;
  logic job_pop;
  logic queue_nonempty;
  job_t job_head;

  // Always take limit transactions; the user must make them arrive only while the block is idle.
  assign limit_ready = 1'b1;

  // Classify bytes, keep decode state and the frame pixel count.
  trle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .code_valid  (code_valid),
    .code_stall  (code_stall),
    .code        (code),
    .limit_valid (limit_valid),
    .limit_data  (limit_data),
    .queue_full  (queue_full),
    .job_push    (job_push),
    .job         (job_in)
  );

  // Decouple the byte side from the pixel side.
  trle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job_in),
    .full     (queue_full),
    .pop      (job_pop),
    .nonempty (queue_nonempty),
    .head     (job_head)
  );

  // Expand each job into its pixels, one per cycle while pixel_stall is low.
  trle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_ready   (queue_nonempty),
    .job         (job_head),
    .job_pop     (job_pop),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

endmodule

// File: verif/tb_tile_rle_byte_decoder_unit.sv
// Self-checking testbench for the tile run-length byte decoder unit.
module tb_tile_rle_byte_decoder_unit;
  import trle_pkg::*;

  // Cycles to let pass after the last expected pixel before touching the
  // limit register: a command byte leaves no pixel but may still be in flight.
  localparam int SETTLE_CYCLES   = 8;
  // Longest run of cycles with no transaction on any channel.
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int BYTES_PER_PHASE = 18;
  localparam int MAX_REPORTS     = 10;

  typedef enum logic {
    ROW_BYTE,
    ROW_LIMIT
  } row_kind_t;

  // One directed step: either a code byte or a limit write. Where checked_here
  // is set, the row carries its own expectation: pixel_count pixels of
  // first_value at consecutive indexes from first_index, run_end on the last.
  typedef struct packed {
    row_kind_t              kind;
    logic                   sof;
    logic [7:0]             code_byte;
    logic                   checked_here;
    logic [6:0]             pixel_count;
    logic [7:0]             first_value;
    logic [INDEX_WIDTH-1:0] first_index;
    logic [LIMIT_WIDTH-1:0] limit;
  } directed_row_t;

  localparam int N_ROWS = 28;

  directed_row_t directed_rows [N_ROWS] = '{
    // new frame, plain pixels at both ends of the literal-pixel range
    '{ROW_BYTE,  1'b1, 8'h00, 1'b1, 7'd1,  8'h00, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b0, 8'h7F, 1'b1, 7'd1,  8'h7F, 20'd1,   21'd0},
    // repeat count field zero means 64
    '{ROW_BYTE,  1'b0, 8'hC0, 1'b1, 7'd0,  8'h00, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b0, 8'hFF, 1'b1, 7'd64, 8'hFF, 20'd2,   21'd0},
    // shortest repeat
    '{ROW_BYTE,  1'b0, 8'hC1, 1'b1, 7'd0,  8'h00, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b0, 8'h00, 1'b1, 7'd1,  8'h00, 20'd66,  21'd0},
    // longest explicit repeat, value byte from the literal command range
    '{ROW_BYTE,  1'b0, 8'hFF, 1'b1, 7'd0,  8'h00, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b0, 8'h80, 1'b0, 7'd0,  8'h00, 20'd0,   21'd0},
    // literal count field zero means 128; command-looking bytes copied as is
    '{ROW_BYTE,  1'b0, 8'h80, 1'b1, 7'd0,  8'h00, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b0, 8'hC5, 1'b0, 7'd0,  8'h00, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b0, 8'h3A, 1'b0, 7'd0,  8'h00, 20'd0,   21'd0},
    // new frame cuts the literal run short and opens another
    '{ROW_BYTE,  1'b1, 8'hBF, 1'b1, 7'd0,  8'h00, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b0, 8'h81, 1'b1, 7'd1,  8'h81, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b1, 8'h81, 1'b1, 7'd0,  8'h00, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b0, 8'hAA, 1'b1, 7'd1,  8'hAA, 20'd0,   21'd0},
    // repeat left without its value byte is dropped by the new frame
    '{ROW_BYTE,  1'b0, 8'hC3, 1'b1, 7'd0,  8'h00, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b1, 8'h05, 1'b1, 7'd1,  8'h05, 20'd0,   21'd0},
    // zero limit: nothing at all comes out
    '{ROW_LIMIT, 1'b0, 8'h00, 1'b0, 7'd0,  8'h00, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b1, 8'h10, 1'b1, 7'd0,  8'h00, 20'd0,   21'd0},
    // limit raised mid-frame, then a repeat cut off at it
    '{ROW_LIMIT, 1'b0, 8'h00, 1'b0, 7'd0,  8'h00, 20'd0,   21'd5},
    '{ROW_BYTE,  1'b0, 8'h11, 1'b1, 7'd1,  8'h11, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b0, 8'hC8, 1'b1, 7'd0,  8'h00, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b0, 8'h42, 1'b1, 7'd4,  8'h42, 20'd1,   21'd0},
    '{ROW_BYTE,  1'b0, 8'h01, 1'b1, 7'd0,  8'h00, 20'd0,   21'd0},
    // limit beyond the index range saturates
    '{ROW_LIMIT, 1'b0, 8'h00, 1'b0, 7'd0,  8'h00, 20'd0,   21'h1FFFFF},
    '{ROW_BYTE,  1'b1, 8'h55, 1'b1, 7'd1,  8'h55, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b0, 8'hFE, 1'b1, 7'd0,  8'h00, 20'd0,   21'd0},
    '{ROW_BYTE,  1'b0, 8'hE7, 1'b0, 7'd0,  8'h00, 20'd0,   21'd0}
  };

  logic                   clk;
  logic                   rst;
  logic                   code_valid;
  logic                   code_stall;
  code_item_t             code;
  logic                   pixel_valid;
  logic                   pixel_stall;
  pixel_item_t            pixel;
  logic                   limit_valid;
  logic                   limit_ready;
  logic [LIMIT_WIDTH-1:0] limit_data;

  tile_rle_byte_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .code_valid  (code_valid),
    .code_stall  (code_stall),
    .code        (code),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .limit_valid (limit_valid),
    .limit_ready (limit_ready),
    .limit_data  (limit_data)
  );

  // Decoder state as the testbench sees it.
  decode_mode_t           mode;
  logic [RUN_WIDTH-1:0]   run_left;
  logic [LIMIT_WIDTH-1:0] pixels_in_frame;
  logic [LIMIT_WIDTH-1:0] cur_limit;

  // Pixels owed by the block, oldest first.
  pixel_item_t pending_pixels [$];

  int  send_gap_pct;
  int  stall_pct;
  logic sof_next;
  int  fail_count;
  int  bytes_sent;
  int  bytes_taken;
  int  pixels_checked;
  int  limit_writes;
  int  frames_started;
  int  quiet_cycles;

  always #4 clk = ~clk;

  // Effective limit: the register saturated at the size of the index space.
  function automatic logic [LIMIT_WIDTH-1:0] frame_cap();
    return (cur_limit > LIMIT_CAP) ? LIMIT_CAP : cur_limit;
  endfunction

  function automatic bit frame_full();
    return pixels_in_frame >= frame_cap();
  endfunction

  function automatic void owe_pixel(logic [7:0] value, logic last);
    pixel_item_t p;
    p.pixel_value = value;
    p.pixel_index = pixels_in_frame[INDEX_WIDTH-1:0];
    p.run_end     = last;
    pending_pixels.push_back(p);
    pixels_in_frame = pixels_in_frame + 1'b1;
  endfunction

  // Advance the decoder by one accepted code byte and queue the pixels it owes.
  // Returns 0 where the byte fell beyond the frame's limit and was ignored.
  function automatic bit decode_code_byte(code_item_t it);
    logic [7:0]             b;
    logic [LIMIT_WIDTH-1:0] cap;
    logic [RUN_WIDTH-1:0]   left;
    b = it.code_byte;
    if (it.start_of_frame) begin
      mode            = MODE_CMD;
      run_left        = '0;
      pixels_in_frame = '0;
      frames_started++;
    end
    cap = frame_cap();
    if (pixels_in_frame >= cap) return 1'b0;
    case (mode)
      MODE_REPEAT: begin
        left = run_left;
        while (left != 0 && pixels_in_frame < cap) begin
          left = left - 1'b1;
          owe_pixel(b, (left == 0) || (pixels_in_frame + 1 >= cap));
        end
        mode     = MODE_CMD;
        run_left = '0;
      end
      MODE_LITERAL: begin
        owe_pixel(b, 1'b1);
        run_left = run_left - 1'b1;
        if (run_left == 0) mode = MODE_CMD;
      end
      default: begin
        if (b >= REPEAT_BASE) begin
          run_left = RUN_WIDTH'(b[5:0] & REPEAT_MASK);
          if (run_left == 0) run_left = REPEAT_MAX;
          mode = MODE_REPEAT;
        end else if (b >= LITERAL_BASE) begin
          run_left = RUN_WIDTH'(b[6:0] & LITERAL_MASK);
          if (run_left == 0) run_left = LITERAL_MAX;
          mode = MODE_LITERAL;
        end else begin
          mode = MODE_CMD;
          owe_pixel(b, 1'b1);
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch: %s", what);
  endfunction

  // Offer one code byte, with a random gap first, and hold it until taken.
  // Reports how many pixels the byte added to the expected queue.
  task automatic send_code(input code_item_t it, output int n_new);
    int owed_earlier;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      code_valid <= 1'b0;
      @(posedge clk);
    end
    code       <= it;
    code_valid <= 1'b1;
    @(posedge clk);
    while (code_stall) @(posedge clk);
    bytes_sent++;
    owed_earlier = pending_pixels.size();
    if (decode_code_byte(it)) bytes_taken++;
    n_new = pending_pixels.size() - owed_earlier;
  endtask

  // Drop valid, wait for every owed pixel, then let the pipeline settle.
  task automatic settle();
    code_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_WIDTH-1:0] value);
    limit_data  <= value;
    limit_valid <= 1'b1;
    @(posedge clk);
    while (!limit_ready) @(posedge clk);
    limit_valid <= 1'b0;
    cur_limit = value;
    limit_writes++;
  endtask

  // Send one byte of random traffic; open a new frame soon after the limit bites.
  task automatic push_byte(input logic [7:0] b);
    code_item_t it;
    int         n;
    it.code_byte      = b;
    it.start_of_frame = sof_next;
    sof_next = 1'b0;
    send_code(it, n);
    if (frame_full() && $urandom_range(0, 99) < 70) sof_next = 1'b1;
  endtask

  // Mostly well-formed runs with random content, the rest broken runs and noise.
  task automatic run_random_phase(input int gap, input int stall,
                                  input logic [LIMIT_WIDTH-1:0] lim);
    int r;
    int len;
    int start;
    settle();
    write_limit(lim);
    send_gap_pct = gap;
    stall_pct    = stall;
    sof_next     = 1'b1;
    start        = bytes_taken;
    while (bytes_taken - start < BYTES_PER_PHASE) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        sof_next = 1'b1;
      end else if (r < 33) begin
        push_byte(8'($urandom_range(0, 127)));
      end else if (r < 58) begin
        push_byte(REPEAT_BASE | 8'($urandom_range(0, 63)));
        // a repeat left hanging by a new frame emits nothing
        if ($urandom_range(0, 99) < 10) sof_next = 1'b1;
        else push_byte(8'($urandom));
      end else if (r < 85) begin
        if ($urandom_range(0, 99) < 8) begin
          // 128-byte run: send a few bytes and cut it short
          push_byte(LITERAL_BASE);
          repeat ($urandom_range(2, 6)) push_byte(8'($urandom));
          sof_next = 1'b1;
        end else begin
          len = $urandom_range(1, 6);
          push_byte(LITERAL_BASE | 8'(len));
          if ($urandom_range(0, 99) < 10) len = $urandom_range(0, len - 1);
          repeat (len) push_byte(8'($urandom));
          if (len == 0) sof_next = 1'b1;
        end
      end else begin
        if ($urandom_range(0, 99) < 20) sof_next = 1'b1;
        push_byte(8'($urandom));
      end
    end
  endtask

  // Receiver side: stall at the rate of the current phase.
  always @(posedge clk) begin
    pixel_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Check each pixel transaction against the oldest owed pixel, field by field.
  always @(posedge clk) begin
    pixel_item_t want;
    if (!rst && pixel_valid && !pixel_stall) begin
      pixels_checked++;
      if (pending_pixels.size() == 0) begin
        note_failure($sformatf("unexpected pixel value %02h index %0d run_end %b",
                               pixel.pixel_value, pixel.pixel_index, pixel.run_end));
      end else begin
        want = pending_pixels.pop_front();
        if (pixel.pixel_value !== want.pixel_value)
          note_failure($sformatf("pixel_value expected %02h got %02h at index %0d",
                                 want.pixel_value, pixel.pixel_value, want.pixel_index));
        if (pixel.pixel_index !== want.pixel_index)
          note_failure($sformatf("pixel_index expected %0d got %0d",
                                 want.pixel_index, pixel.pixel_index));
        if (pixel.run_end !== want.run_end)
          note_failure($sformatf("run_end expected %b got %b at index %0d",
                                 want.run_end, pixel.run_end, want.pixel_index));
      end
    end
  end

  // Watchdog: give up when no channel has moved a transaction for too long.
  always @(posedge clk) begin
    if (rst || (code_valid && !code_stall) || (pixel_valid && !pixel_stall) ||
        (limit_valid && limit_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d pixels outstanding", pending_pixels.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    code_item_t it;
    int         n;
    clk             = 1'b0;
    rst             = 1'b1;
    code_valid      = 1'b0;
    code            = '0;
    pixel_stall     = 1'b0;
    limit_valid     = 1'b0;
    limit_data      = '0;
    send_gap_pct    = 0;
    stall_pct       = 0;
    sof_next        = 1'b0;
    fail_count      = 0;
    bytes_sent      = 0;
    bytes_taken     = 0;
    pixels_checked  = 0;
    limit_writes    = 0;
    frames_started  = 0;
    quiet_cycles    = 0;
    mode            = MODE_CMD;
    run_left        = '0;
    pixels_in_frame = '0;
    cur_limit       = LIMIT_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table, no idling on either side.
    for (int r = 0; r < N_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_LIMIT) begin
        settle();
        write_limit(directed_rows[r].limit);
      end else begin
        it.code_byte      = directed_rows[r].code_byte;
        it.start_of_frame = directed_rows[r].sof;
        send_code(it, n);
        if (directed_rows[r].checked_here) begin
          // replace what the decoder worked out with the row's own expectation
          repeat (n) void'(pending_pixels.pop_back());
          for (int k = 0; k < directed_rows[r].pixel_count; k++) begin
            pending_pixels.push_back('{
              pixel_value: directed_rows[r].first_value,
              pixel_index: directed_rows[r].first_index + INDEX_WIDTH'(k),
              run_end:     (k == directed_rows[r].pixel_count - 1)});
          end
        end
      end
    end

    // Random traffic under each idling pattern and a different limit each time.
    run_random_phase(0,  0,  LIMIT_RESET);
    run_random_phase(72, 0,  LIMIT_WIDTH'($urandom_range(20, 120)));
    run_random_phase(0,  72, LIMIT_WIDTH'($urandom_range(1, 1048576)));
    run_random_phase(26, 26, LIMIT_WIDTH'($urandom_range(1, 12)));

    // Drain, then allow for stray pixels before judging.
    settle();
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0)
      note_failure($sformatf("%0d expected pixels never arrived", pending_pixels.size()));

    $display("covered %0d code bytes (%0d decoded) over %0d frames, %0d limit writes",
             bytes_sent, bytes_taken, frames_started, limit_writes);
    $display("checked %0d pixels, %0d failures", pixels_checked, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/trle_pkg.sv
rtl/core/trle_front.sv
rtl/core/trle_queue.sv
rtl/core/trle_back.sv
rtl/core/tile_rle_byte_decoder_unit.sv
verif/tb_tile_rle_byte_decoder_unit.sv
